>>> sv/stg_pkg.sv
// shared types and constants of the sawtooth test frame generator
package stg_pkg;

	// default sizes handed to the top level
	localparam int CHANNELS_DEF    = 8;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int MAX_RECORDS_DEF = 64;

	// fixed widths of the fields and registers
	localparam int SAW_CHANNELS = 5;
	localparam int STEP_W       = 28;
	localparam int RPP_W        = 7;
	localparam int SHIFT_W      = 16;
	localparam int TS_W         = 16;
	localparam int PAT_W        = 16;
	localparam int SAMPLE_W     = 12;
	localparam int BYTE_W       = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 28;
	localparam int IN_DATA_W    = 8;

	// record framing
	localparam logic [BYTE_W-1:0]   SYNC_A     = 8'h55;
	localparam logic [BYTE_W-1:0]   SYNC_B     = 8'h33;
	localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = 12'd4095;

	// register reset values
	localparam logic [STEP_W-1:0] STEP_RESET [SAW_CHANNELS] = '{
		28'd26843546, 28'd2684355, 28'd268435, 28'd26844, 28'd2684
	};
	localparam logic [RPP_W-1:0]   RPP_RESET   = 7'd50;
	localparam logic [SHIFT_W-1:0] SHIFT_RESET = 16'd3000;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STEP0 = 3'd0,
		REG_STEP1 = 3'd1,
		REG_STEP2 = 3'd2,
		REG_STEP3 = 3'd3,
		REG_STEP4 = 3'd4,
		REG_RPP   = 3'd5,
		REG_SHIFT = 3'd6
	} reg_idx_t;

	// control handed from the record builder to the serialiser
	typedef struct packed {
		logic valid;
		logic pkt_done;
	} rec_ctl_t;

endpackage

>>> sv/sawtooth_test_frame_generator_core.sv
// top level of the sawtooth test frame generator
// a tick passes the input stage and record registers, its first byte then the
// serialiser shift and output registers; one record of 6 + 2*CHANNELS bytes (22)
// per tick, sent one byte per cycle unless m_axis_tready stalls the serialiser
// a tick transaction with tick low is taken and produces nothing
// reset: asynchronous, active low; clears state, loads default register values
module sawtooth_test_frame_generator_core #(
	parameter int CHANNELS    = stg_pkg::CHANNELS_DEF,
	parameter int FRAC_BITS   = stg_pkg::FRAC_BITS_DEF,
	parameter int MAX_RECORDS = stg_pkg::MAX_RECORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [stg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [stg_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [0] tick, [7:1] zero
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [stg_pkg::BYTE_W-1:0]      m_axis_tdata,   // [7:0] data_byte
	output logic                            m_axis_tlast,   // last_of_record
	output logic                            m_axis_tuser    // [0] last_of_packet
);

	localparam int REC_W = (6 + 2 * CHANNELS) * stg_pkg::BYTE_W;

	stg_pkg::rec_ctl_t rec_ctl;
	logic [REC_W-1:0]  rec_data;
	logic              rec_ready;

	// state update and record building
	stg_update #(
		.CHANNELS    (CHANNELS),
		.FRAC_BITS   (FRAC_BITS),
		.MAX_RECORDS (MAX_RECORDS)
	) u_update (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_tick   (s_axis_tdata[0]),
		.in_ready  (s_axis_tready),
		.rec_ctl   (rec_ctl),
		.rec_data  (rec_data),
		.rec_ready (rec_ready)
	);

	// byte serialiser
	stg_ser #(
		.CHANNELS (CHANNELS)
	) u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.rec_ctl   (rec_ctl),
		.rec_data  (rec_data),
		.rec_ready (rec_ready),
		.out_valid (m_axis_tvalid),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.out_pkt   (m_axis_tuser),
		.out_ready (m_axis_tready)
	);

endmodule

>>> sv/stg_update.sv
// input stage, generator state update and record builder
module stg_update #(
	parameter int CHANNELS    = stg_pkg::CHANNELS_DEF,
	parameter int FRAC_BITS   = stg_pkg::FRAC_BITS_DEF,
	parameter int MAX_RECORDS = stg_pkg::MAX_RECORDS_DEF,
	localparam int REC_W      = (6 + 2 * CHANNELS) * stg_pkg::BYTE_W
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [stg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [stg_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	input  logic                            in_tick,
	output logic                            in_ready,
	output stg_pkg::rec_ctl_t               rec_ctl,
	output logic [REC_W-1:0]                rec_data,
	input  logic                            rec_ready
);

	localparam int ACC_W  = stg_pkg::SAMPLE_W + FRAC_BITS;
	localparam int SUM_W  = ((ACC_W > stg_pkg::STEP_W) ? ACC_W : stg_pkg::STEP_W) + 1;
	localparam int RIP_W  = $clog2(MAX_RECORDS + 1);
	localparam int NSAW   = (CHANNELS < stg_pkg::SAW_CHANNELS) ? CHANNELS
		: stg_pkg::SAW_CHANNELS;
	localparam logic [SUM_W-1:0] TOP_VAL =
		SUM_W'(stg_pkg::SAMPLE_TOP) << FRAC_BITS;
	localparam logic [stg_pkg::RPP_W-1:0] MAX_LIM = stg_pkg::RPP_W'(MAX_RECORDS);

	// configuration registers
	logic [stg_pkg::STEP_W-1:0]  step_q [stg_pkg::SAW_CHANNELS];
	logic [stg_pkg::RPP_W-1:0]   rpp_q;
	logic [stg_pkg::SHIFT_W-1:0] shift_q;

	// generator state
	logic [ACC_W-1:0]            acc_q [stg_pkg::SAW_CHANNELS];
	logic [stg_pkg::TS_W-1:0]    ts_q;
	logic [stg_pkg::PAT_W-1:0]   pat_q;
	logic [stg_pkg::SHIFT_W-1:0] stc_q;
	logic [RIP_W-1:0]            rip_q;

	// input stage and record register
	logic             vld_s1;
	logic             tick_s1;
	logic             rec_vld_q;
	logic             rec_pkt_q;
	logic [REC_W-1:0] rec_q;

	// next values
	logic [ACC_W-1:0]              acc_d [stg_pkg::SAW_CHANNELS];
	logic [stg_pkg::TS_W-1:0]      ts_d;
	logic [stg_pkg::PAT_W-1:0]     pat_d;
	logic [stg_pkg::SHIFT_W-1:0]   stc_inc;
	logic [stg_pkg::SHIFT_W-1:0]   stc_d;
	logic [stg_pkg::RPP_W-1:0]     limit;
	logic [RIP_W-1:0]              rip_inc;
	logic                          pkt_done;
	logic [REC_W-1:0]              rec_d;
	logic [SUM_W-1:0]              sum [stg_pkg::SAW_CHANNELS];
	logic                          rec_free;
	logic                          consume;
	logic                          do_tick;

	// handshake between stages
	assign rec_free = !rec_vld_q || rec_ready;
	assign consume  = vld_s1 && (!tick_s1 || rec_free);
	assign do_tick  = consume && tick_s1;
	assign in_ready = !vld_s1 || consume;

	// phase accumulators, reset to zero above the top instead of wrapping
	always_comb begin
		for (int c = 0; c < stg_pkg::SAW_CHANNELS; c++) begin
			sum[c]   = SUM_W'(acc_q[c]) + SUM_W'(step_q[c]);
			acc_d[c] = (sum[c] > TOP_VAL) ? '0 : sum[c][ACC_W-1:0];
		end
	end

	// timestamp, pattern shift and packet counting
	always_comb begin
		ts_d    = ts_q + 1'b1;
		stc_inc = stc_q + 1'b1;
		if (stc_inc > shift_q) begin
			stc_d = '0;
			pat_d = {pat_q[stg_pkg::PAT_W-2:0], 1'b0} + 1'b1;
		end else begin
			stc_d = stc_inc;
			pat_d = pat_q + 1'b1;
		end
		if (rpp_q == '0) begin
			limit = stg_pkg::RPP_W'(1);
		end else if (rpp_q > MAX_LIM) begin
			limit = MAX_LIM;
		end else begin
			limit = rpp_q;
		end
		rip_inc  = rip_q + 1'b1;
		pkt_done = stg_pkg::RPP_W'(rip_inc) >= limit;
	end

	// record assembly, first byte in the top bits
	always_comb begin
		rec_d = '0;
		rec_d[REC_W-1 -: 2*stg_pkg::BYTE_W]  = {stg_pkg::SYNC_A, stg_pkg::SYNC_B};
		rec_d[REC_W-17 -: stg_pkg::TS_W]     = ts_d;
		for (int c = 0; c < NSAW; c++) begin
			rec_d[REC_W-33-16*c -: 16] =
				{4'b0, acc_d[c][FRAC_BITS +: stg_pkg::SAMPLE_W]};
		end
		rec_d[stg_pkg::PAT_W-1:0] = pat_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < stg_pkg::SAW_CHANNELS; c++) begin
				step_q[c] <= stg_pkg::STEP_RESET[c];
			end
			rpp_q   <= stg_pkg::RPP_RESET;
			shift_q <= stg_pkg::SHIFT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				stg_pkg::REG_STEP0: step_q[0] <= cfg_data;
				stg_pkg::REG_STEP1: step_q[1] <= cfg_data;
				stg_pkg::REG_STEP2: step_q[2] <= cfg_data;
				stg_pkg::REG_STEP3: step_q[3] <= cfg_data;
				stg_pkg::REG_STEP4: step_q[4] <= cfg_data;
				stg_pkg::REG_RPP:   rpp_q     <= cfg_data[stg_pkg::RPP_W-1:0];
				stg_pkg::REG_SHIFT: shift_q   <= cfg_data[stg_pkg::SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// generator state update on each tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < stg_pkg::SAW_CHANNELS; c++) begin
				acc_q[c] <= '0;
			end
			ts_q  <= '0;
			pat_q <= '0;
			stc_q <= '0;
			rip_q <= '0;
		end else if (do_tick) begin
			for (int c = 0; c < stg_pkg::SAW_CHANNELS; c++) begin
				acc_q[c] <= acc_d[c];
			end
			ts_q  <= ts_d;
			pat_q <= pat_d;
			stc_q <= stc_d;
			rip_q <= pkt_done ? '0 : rip_inc;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			rec_vld_q <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (do_tick) begin
				rec_vld_q <= 1'b1;
			end else if (rec_ready) begin
				rec_vld_q <= 1'b0;
			end
		end
	end

	// input and record payload
	always_ff @(posedge clk) begin
		if (in_ready) begin
			tick_s1 <= in_tick;
		end
		if (do_tick) begin
			rec_q     <= rec_d;
			rec_pkt_q <= pkt_done;
		end
	end

	assign rec_ctl.valid    = rec_vld_q;
	assign rec_ctl.pkt_done = rec_pkt_q;
	assign rec_data         = rec_q;

endmodule

>>> sv/stg_ser.sv
// record serialiser, one byte per transaction from a registered output
module stg_ser #(
	parameter int CHANNELS = stg_pkg::CHANNELS_DEF,
	localparam int REC_BYTES = 6 + 2 * CHANNELS,
	localparam int REC_W     = REC_BYTES * stg_pkg::BYTE_W
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stg_pkg::rec_ctl_t            rec_ctl,
	input  logic [REC_W-1:0]             rec_data,
	output logic                         rec_ready,
	output logic                         out_valid,
	output logic [stg_pkg::BYTE_W-1:0]   out_byte,
	output logic                         out_last,
	output logic                         out_pkt,
	input  logic                         out_ready
);

	localparam int CNT_W = $clog2(REC_BYTES + 1);

	logic [REC_W-1:0]           sh_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       pkt_q;
	logic                       out_vld_q;
	logic [stg_pkg::BYTE_W-1:0] out_byte_q;
	logic                       out_last_q;
	logic                       out_pkt_q;
	logic                       out_free;
	logic                       busy;
	logic                       final_byte;
	logic                       load;

	// a new record is taken as the final byte of the previous one leaves
	assign out_free   = !out_vld_q || out_ready;
	assign busy       = cnt_q != '0;
	assign final_byte = cnt_q == CNT_W'(1);
	assign rec_ready  = !busy || (final_byte && out_free);
	assign load       = rec_ctl.valid && rec_ready;

	// byte counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (load) begin
				cnt_q <= CNT_W'(REC_BYTES);
			end else if (out_free && busy) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (out_free) begin
				out_vld_q <= busy;
			end
		end
	end

	// shift register and output payload
	always_ff @(posedge clk) begin
		if (load) begin
			sh_q  <= rec_data;
			pkt_q <= rec_ctl.pkt_done;
		end else if (out_free && busy) begin
			sh_q <= sh_q << stg_pkg::BYTE_W;
		end
		if (out_free && busy) begin
			out_byte_q <= sh_q[REC_W-1 -: stg_pkg::BYTE_W];
			out_last_q <= final_byte;
			out_pkt_q  <= final_byte && pkt_q;
		end
	end

	assign out_valid = out_vld_q;
	assign out_byte  = out_byte_q;
	assign out_last  = out_last_q;
	assign out_pkt   = out_pkt_q;

endmodule

>>> sv/stg_checker.sv
// port-level checker of the sawtooth test frame generator, with its bind
module stg_checker #(
	parameter int CHANNELS = stg_pkg::CHANNELS_DEF
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [stg_pkg::BYTE_W-1:0]    m_axis_tdata,
	input logic                          m_axis_tlast,
	input logic                          m_axis_tuser
);

	localparam int REC_BYTES = 6 + 2 * CHANNELS;
	localparam int CNT_W     = $clog2(REC_BYTES);

	logic             out_xfer;
	logic [CNT_W-1:0] pos_q;

	assign out_xfer = m_axis_tvalid && m_axis_tready;

	// byte position within the current record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (out_xfer) begin
			pos_q <= m_axis_tlast ? '0 : pos_q + 1'b1;
		end
	end

	// a stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output byte changed while stalled");

	// packet end only on a record end
	a_pkt_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("packet end without record end");

	// record end exactly on the final byte of the record
	a_rec_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> (m_axis_tlast == (pos_q == CNT_W'(REC_BYTES - 1))))
		else $error("record length wrong");

	// each record opens with its two sync bytes
	a_sync_a: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && pos_q == '0 |-> m_axis_tdata == stg_pkg::SYNC_A)
		else $error("first sync byte missing");

	a_sync_b: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && pos_q == CNT_W'(1) |-> m_axis_tdata == stg_pkg::SYNC_B)
		else $error("second sync byte missing");

endmodule

bind sawtooth_test_frame_generator_core stg_checker #(
	.CHANNELS (CHANNELS)
) u_stg_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
